@@ rtl/scd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package scd_pkg;
  localparam int unsigned PosW  = 16;
  localparam int unsigned VelW  = 12;
  localparam int unsigned DistW = 17;
  localparam int unsigned FracBits = 4;
  localparam int unsigned MaxSteps = 128;
  // Offset numerator mag*i*16 <= 2048*128*16 = 2^22.
  localparam int unsigned NumW  = 23;
  localparam int unsigned QW    = 20;
  localparam int unsigned DiffW = 21;
  localparam int unsigned SqW   = 42;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SQ    = 3'd2;
  localparam logic [2:0] ST_SQRT  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;
endpackage
`default_nettype wire

@@ rtl/scd_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle. Four divides run in lanes.
module scd_div (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [3:0][scd_pkg::NumW-1:0] num_i,
  input  wire logic [scd_pkg::VelW-1:0] den_i,
  output logic                         done_o,
  output logic [3:0][scd_pkg::QW-1:0]  quo_o
);
  import scd_pkg::*;
  logic [4:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [3:0][NumW-1:0] num_q, num_d;
  logic [3:0][VelW:0]   rem_q, rem_d;
  logic [3:0][QW-1:0]   quo_q, quo_d;
  logic [VelW-1:0] den_q;

  always_comb begin
    logic [VelW:0] t;
    t = '0;
    busy_d = busy_q; cnt_d = cnt_q; num_d = num_q; rem_d = rem_q; quo_d = quo_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1; cnt_d = 5'(NumW); num_d = num_i; rem_d = '0; quo_d = '0;
    end else if (busy_q) begin
      for (int k = 0; k < 4; k++) begin
        t = {rem_q[k][VelW-1:0], num_q[k][NumW-1]};
        num_d[k] = {num_q[k][NumW-2:0], 1'b0};
        if (t >= {1'b0, den_q}) begin
          rem_d[k] = t - {1'b0, den_q};
          quo_d[k] = {quo_q[k][QW-2:0], 1'b1};
        end else begin
          rem_d[k] = t;
          quo_d[k] = {quo_q[k][QW-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end
  assign quo_o = quo_d;
endmodule
`default_nettype wire

@@ rtl/scd_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Digit-by-digit square root, one result bit per cycle.
module scd_sqrt (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [scd_pkg::SqW-1:0]  rad_i,
  output logic                          done_o,
  output logic [scd_pkg::DistW-1:0]     root_o
);
  import scd_pkg::*;
  logic busy_q;
  logic [4:0] cnt_q;
  logic [SqW-1:0] n_q;
  logic [SqW/2+1:0] rem_q;
  logic [SqW/2-1:0] res_q;
  logic [SqW/2+1:0] t, trial;

  assign t = {rem_q[SqW/2-1:0], n_q[SqW-1 -: 2]};
  assign trial = {res_q, 2'b01};
  assign done_o = busy_q && cnt_q == 5'd0;
  assign root_o = res_q[DistW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1; cnt_q <= 5'(SqW / 2);
    end else if (busy_q) begin
      if (cnt_q == 5'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 5'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= rad_i; rem_q <= '0; res_q <= '0;
    end else if (busy_q && cnt_q != 5'd0) begin
      n_q <= {n_q[SqW-3:0], 2'b00};
      if (t >= trial) begin
        rem_q <= t - trial;
        res_q <= {res_q[SqW/2-2:0], 1'b1};
      end else begin
        rem_q <= t;
        res_q <= {res_q[SqW/2-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/swept_closest_distance.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Each transaction covers S samples (1..129). Sample 0 takes two squaring steps (x then y);
// each later sample adds a pass of the shared restoring divider (four lanes, 23 quotient
// bits, low 20 kept) and two squaring steps. The final root comes from the square root.
// in_ready_o is high only in idle, so a new transaction is accepted only after the
// previous result has been taken.
// Reset (async, active low) returns the sequencer to idle, output empty.
module swept_closest_distance (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic signed [15:0] a_pos_x_i,
  input  wire logic signed [15:0] a_pos_y_i,
  input  wire logic signed [11:0] a_vel_x_i,
  input  wire logic signed [11:0] a_vel_y_i,
  input  wire logic signed [15:0] b_pos_x_i,
  input  wire logic signed [15:0] b_pos_y_i,
  input  wire logic signed [11:0] b_vel_x_i,
  input  wire logic signed [11:0] b_vel_y_i,
  input  wire logic [15:0] contact_radius_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic [16:0] closest_distance_o,
  output logic      hit_o
);
  import scd_pkg::*;
  logic [2:0] st_q;
  logic signed [PosW-1:0] apx_q, apy_q, bpx_q, bpy_q;
  logic [3:0] neg_q;
  logic [3:0][VelW-1:0] vm_q;
  logic [VelW-1:0] dmax_q;
  logic [15:0] rad_q;
  logic [7:0] i_q, last_q;
  logic [SqW-1:0] best_q, acc_q;
  logic [3:0][QW-1:0] off_q;
  logic axis_q, dv_q, sqs_q;
  logic [3:0][NumW-1:0] num;
  logic [3:0][QW-1:0] quo;
  logic div_done, sq_done;
  logic [DistW-1:0] root;
  logic [3:0][VelW-1:0] vm_in;
  logic [VelW-1:0] m01, m23, dmax_in;
  logic [VelW-FracBits-1:0] steps;
  logic signed [DiffW-1:0] dif;
  logic [DiffW-1:0] dmag;
  logic [SqW-1:0] sq;

  function automatic logic [VelW-1:0] absv(input logic signed [VelW-1:0] v);
    absv = v[VelW-1] ? VelW'(-v) : v;
  endfunction
  function automatic logic signed [DiffW-1:0] so(input logic n,
                                                input logic [QW-1:0] q);
    so = n ? -DiffW'(q) : DiffW'(q);
  endfunction

  assign vm_in[0] = absv(a_vel_x_i);
  assign vm_in[1] = absv(a_vel_y_i);
  assign vm_in[2] = absv(b_vel_x_i);
  assign vm_in[3] = absv(b_vel_y_i);
  assign m01 = vm_in[0] > vm_in[1] ? vm_in[0] : vm_in[1];
  assign m23 = vm_in[2] > vm_in[3] ? vm_in[2] : vm_in[3];
  assign dmax_in = m01 > m23 ? m01 : m23;
  assign steps = dmax_in[VelW-1:FracBits];

  for (genvar k = 0; k < 4; k++) begin : g_num
    assign num[k] = NumW'(vm_q[k]) * NumW'(i_q) * NumW'(1 << FracBits);
  end

  scd_div u_div (.clk_i, .rst_ni, .start_i(dv_q), .num_i(num), .den_i(dmax_q),
    .done_o(div_done), .quo_o(quo));

  // One shared squarer: x then y. Sample 0 uses zero offsets.
  always_comb begin
    if (!axis_q)
      dif = (DiffW'(apx_q) + so(neg_q[0], off_q[0]))
          - (DiffW'(bpx_q) + so(neg_q[2], off_q[2]));
    else
      dif = (DiffW'(apy_q) + so(neg_q[1], off_q[1]))
          - (DiffW'(bpy_q) + so(neg_q[3], off_q[3]));
    dmag = dif[DiffW-1] ? DiffW'(-dif) : dif;
    sq = SqW'(dmag) * SqW'(dmag);
  end

  scd_sqrt u_sqrt (.clk_i, .rst_ni, .start_i(sqs_q), .rad_i(best_q),
    .done_o(sq_done), .root_o(root));

  assign in_ready_o = st_q == ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; out_valid_o <= 1'b0; dv_q <= 1'b0; sqs_q <= 1'b0;
      axis_q <= 1'b0;
    end else begin
      dv_q <= 1'b0; sqs_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: if (in_valid_i) begin
          st_q <= ST_SQ; axis_q <= 1'b0;
        end
        ST_DIV: if (div_done) begin
          st_q <= ST_SQ; axis_q <= 1'b0;
        end
        ST_SQ: begin
          axis_q <= ~axis_q;
          if (axis_q) begin
            if (i_q == last_q) begin
              st_q <= ST_SQRT; sqs_q <= 1'b1;
            end else begin
              st_q <= ST_DIV; dv_q <= 1'b1;
            end
          end
        end
        ST_SQRT: if (sq_done) begin
          st_q <= ST_OUT; out_valid_o <= 1'b1;
        end
        ST_OUT: if (out_ready_i) begin
          st_q <= ST_IDLE; out_valid_o <= 1'b0;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_valid_i) begin
      apx_q <= a_pos_x_i; apy_q <= a_pos_y_i;
      bpx_q <= b_pos_x_i; bpy_q <= b_pos_y_i;
      neg_q <= {b_vel_y_i[VelW-1], b_vel_x_i[VelW-1], a_vel_y_i[VelW-1],
                a_vel_x_i[VelW-1]};
      vm_q <= vm_in; dmax_q <= dmax_in; rad_q <= contact_radius_i;
      last_q <= (steps > 8'(MaxSteps)) ? 8'(MaxSteps) : 8'(steps);
      i_q <= '0; off_q <= '0; best_q <= '1;
    end
    if (st_q == ST_SQ && axis_q && i_q != last_q) i_q <= i_q + 8'd1;
    if (st_q == ST_DIV && div_done) off_q <= quo;
    if (st_q == ST_SQ) begin
      if (!axis_q) acc_q <= sq;
      else if (acc_q + sq < best_q) best_q <= acc_q + sq;
    end
    if (st_q == ST_SQRT && sq_done) begin
      closest_distance_o <= root;
      hit_o <= root < {1'b0, rad_q};
    end
  end
endmodule
`default_nettype wire
